>>> rtl/core/fhts_pkg.sv
// Shared types and constants for the fan hour timers and sleep controller.
package fhts_pkg;

    localparam int HOUR_BITS_DEFAULT = 4;

    // request codes
    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_STATE     = 3'd1;
    localparam logic [2:0] REQ_LOAD_ON   = 3'd2;
    localparam logic [2:0] REQ_LOAD_OFF  = 3'd3;
    localparam logic [2:0] REQ_SET_SLEEP = 3'd4;

    // machine state codes
    localparam logic [1:0] MS_NONE = 2'd0;
    localparam logic [1:0] MS_WORK = 2'd1;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOUR_SECONDS       = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SLEEP_STEP_SECONDS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SLEEP_STEPS        = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDLE_SECONDS       = 2'd3;

    localparam logic [15:0] HOUR_SECONDS_RST       = 16'd3600;
    localparam logic [15:0] SLEEP_STEP_SECONDS_RST = 16'd1800;
    localparam logic [7:0]  SLEEP_STEPS_RST        = 8'd16;
    localparam logic [15:0] IDLE_SECONDS_RST       = 16'd30;

    typedef struct packed {
        logic [2:0] req_type;
        logic [1:0] machine_state;
        logic [3:0] load_value;
    } fhts_in_t;

    typedef struct packed {
        logic [3:0] on_hours_left;
        logic [3:0] off_hours_left;
        logic [1:0] on_indicator;
        logic [1:0] off_indicator;
        logic       sleep_active;
        logic       light_sleep;
        logic       beep;
        logic       request_power_on;
        logic       request_stop;
    } fhts_out_t;

    // control for one hour timer
    typedef struct packed {
        logic       tick;
        logic       run;
        logic       load;
        logic [3:0] load_value;
    } hour_ctl_t;

endpackage

>>> rtl/core/fan_hour_timers_and_sleep.sv
// Top level: fan on/off hour timers, sleep timer and light-sleep counter.
// An accepted input word passes through the input register and the result register to m_.
// One word per cycle while m_ready does not stall the result register; input register feeds one pass of timer
// logic into the result register, with state updated as the word passes.
// Reset (aresetn low, synchronous): all timers, flags and indicators clear,
// configuration registers return to 3600 / 1800 / 16 / 30, both stages empty.
module fan_hour_timers_and_sleep #(
    parameter int HOUR_BITS = fhts_pkg::HOUR_BITS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  fhts_pkg::fhts_in_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output fhts_pkg::fhts_out_t                   m_data,
    input  logic                                  cfg_we,
    input  logic [fhts_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [15:0]                           cfg_wdata
);
    import fhts_pkg::*;

    logic [15:0] hour_seconds_reg, sleep_step_seconds_reg, idle_seconds_reg;
    logic [7:0]  sleep_steps_reg;

    fhts_in_t  in_reg;
    logic      in_valid_reg;
    fhts_out_t out_reg, out_next;
    logic      out_valid_reg;
    logic      advance;

    logic is_tick, is_none, is_work;
    hour_ctl_t on_ctl, off_ctl;
    logic [HOUR_BITS-1:0] on_hours_next, off_hours_next;
    logic [1:0] on_code_next, off_code_next;
    logic on_expire, off_expire;

    logic        sleep_flag_reg, sleep_flag_next;
    logic [15:0] sleep_tick_reg, sleep_tick_next;
    logic [7:0]  sleep_step_reg, sleep_step_next;
    logic        sleep_expire;
    logic [15:0] idle_count_reg, idle_count_next;
    logic        light_flag_reg, light_flag_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign is_tick = (in_reg.req_type == REQ_TICK);
    assign is_none = (in_reg.machine_state == MS_NONE);
    assign is_work = (in_reg.machine_state == MS_WORK);

    always_comb begin
        on_ctl.tick        = is_tick;
        on_ctl.run         = is_none;
        on_ctl.load        = (in_reg.req_type == REQ_LOAD_ON);
        on_ctl.load_value  = in_reg.load_value;
        off_ctl.tick       = is_tick;
        off_ctl.run        = is_work;
        off_ctl.load       = (in_reg.req_type == REQ_LOAD_OFF);
        off_ctl.load_value = in_reg.load_value;
    end

    fhts_hour_timer #(.HOUR_BITS(HOUR_BITS)) u_on_timer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .ctl          (on_ctl),
        .hour_seconds (hour_seconds_reg),
        .hours_next   (on_hours_next),
        .code_next    (on_code_next),
        .expire       (on_expire)
    );

    fhts_hour_timer #(.HOUR_BITS(HOUR_BITS)) u_off_timer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .ctl          (off_ctl),
        .hour_seconds (hour_seconds_reg),
        .hours_next   (off_hours_next),
        .code_next    (off_code_next),
        .expire       (off_expire)
    );

    // sleep timer and light-sleep counter
    always_comb begin
        sleep_flag_next = sleep_flag_reg;
        sleep_tick_next = sleep_tick_reg;
        sleep_step_next = sleep_step_reg;
        sleep_expire    = 1'b0;
        idle_count_next = idle_count_reg;
        light_flag_next = light_flag_reg;
        if (is_tick) begin
            if (sleep_flag_reg && is_work) begin
                if ({1'b0, sleep_tick_reg} + 17'd1 >= {1'b0, sleep_step_seconds_reg}) begin
                    sleep_tick_next = '0;
                    if ({1'b0, sleep_step_reg} + 9'd1 >= {1'b0, sleep_steps_reg}) begin
                        sleep_step_next = '0;
                        sleep_flag_next = 1'b0;
                        sleep_expire    = 1'b1;
                    end else begin
                        sleep_step_next = sleep_step_reg + 8'd1;
                    end
                end else begin
                    sleep_tick_next = sleep_tick_reg + 16'd1;
                end
            end else begin
                sleep_tick_next = '0;
                sleep_step_next = '0;
            end
            if (is_work && !light_flag_reg) begin
                if ({1'b0, idle_count_reg} + 17'd1 >= {1'b0, idle_seconds_reg}) begin
                    idle_count_next = '0;
                    light_flag_next = 1'b1;
                end else begin
                    idle_count_next = idle_count_reg + 16'd1;
                end
            end
        end else if (in_reg.req_type == REQ_SET_SLEEP) begin
            sleep_flag_next = (in_reg.load_value != 4'd0);
        end
        // standby clears light sleep on every word
        if (is_none) begin
            idle_count_next = '0;
            light_flag_next = 1'b0;
        end
    end

    always_comb begin
        out_next.on_hours_left    = 4'(on_hours_next);
        out_next.off_hours_left   = 4'(off_hours_next);
        out_next.on_indicator     = on_code_next;
        out_next.off_indicator    = off_code_next;
        out_next.sleep_active     = sleep_flag_next;
        out_next.light_sleep      = light_flag_next;
        out_next.beep             = on_expire || off_expire || sleep_expire;
        out_next.request_power_on = on_expire;
        out_next.request_stop     = off_expire || sleep_expire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_seconds_reg       <= HOUR_SECONDS_RST;
            sleep_step_seconds_reg <= SLEEP_STEP_SECONDS_RST;
            sleep_steps_reg        <= SLEEP_STEPS_RST;
            idle_seconds_reg       <= IDLE_SECONDS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_HOUR_SECONDS:       hour_seconds_reg       <= cfg_wdata;
                CFG_SLEEP_STEP_SECONDS: sleep_step_seconds_reg <= cfg_wdata;
                CFG_SLEEP_STEPS:        sleep_steps_reg        <= cfg_wdata[7:0];
                CFG_IDLE_SECONDS:       idle_seconds_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            sleep_flag_reg <= 1'b0;
            sleep_tick_reg <= '0;
            sleep_step_reg <= '0;
            idle_count_reg <= '0;
            light_flag_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                sleep_flag_reg <= sleep_flag_next;
                sleep_tick_reg <= sleep_tick_next;
                sleep_step_reg <= sleep_step_next;
                idle_count_reg <= idle_count_next;
                light_flag_reg <= light_flag_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule

>>> rtl/core/fhts_hour_timer.sv
// Hour countdown timer with tick counter and indicator code.
module fhts_hour_timer #(
    parameter int HOUR_BITS = fhts_pkg::HOUR_BITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  fhts_pkg::hour_ctl_t   ctl,
    input  logic [15:0]           hour_seconds,
    output logic [HOUR_BITS-1:0]  hours_next,
    output logic [1:0]            code_next,
    output logic                  expire
);
    import fhts_pkg::*;

    logic [HOUR_BITS-1:0] hours_reg;
    logic [15:0]          count_reg, count_next;
    logic [1:0]           code_reg;
    logic                 running;

    assign running = ctl.run && (hours_reg != '0);

    always_comb begin
        hours_next = hours_reg;
        count_next = count_reg;
        code_next  = code_reg;
        expire     = 1'b0;
        if (ctl.tick) begin
            if (running) begin
                if ({1'b0, count_reg} + 17'd1 >= {1'b0, hour_seconds}) begin
                    count_next = '0;
                    hours_next = hours_reg - HOUR_BITS'(1);
                    // hold the code while more than three hours remain
                    if (hours_next <= HOUR_BITS'(3)) begin
                        code_next = hours_next[1:0];
                    end
                    expire = (hours_next == '0);
                end else begin
                    count_next = count_reg + 16'd1;
                end
            end else begin
                count_next = '0;
            end
        end else if (ctl.load) begin
            hours_next = HOUR_BITS'(ctl.load_value);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hours_reg <= '0;
            count_reg <= '0;
            code_reg  <= '0;
        end else if (advance) begin
            hours_reg <= hours_next;
            count_reg <= count_next;
            code_reg  <= code_next;
        end
    end

endmodule

>>> rtl/core/fhts_checker.sv
// Port-level checks for the fan hour timers block, with its bind.
module fhts_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input fhts_pkg::fhts_out_t m_data
);
    import fhts_pkg::*;

    // a beep comes only with a power-on or stop request, and always with one
    a_beep_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.beep == (m_data.request_power_on || m_data.request_stop)))
        else $error("beep does not match its requests");

    // power-on fires only as the on-timer runs out
    a_power_on_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.request_power_on) |->
            (m_data.on_hours_left == 4'd0 && m_data.on_indicator == 2'd0))
        else $error("power-on request with on hours left");

    // a stop with no off-timer expiry must come from the sleep timer
    a_stop_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.request_stop && m_data.off_hours_left != 4'd0) |->
            !m_data.sleep_active)
        else $error("stop request with no expired timer");

    // hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result word changed while stalled");

endmodule

bind fan_hour_timers_and_sleep fhts_checker u_fhts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> bench/tb_top.sv
// Self-checking bench for the fan hour timers and sleep controller.
`timescale 1ns / 100ps

module tb_top;
    import fhts_pkg::*;

    // codes the package leaves unnamed
    localparam logic [2:0] REQ_SPARE_A = 3'd5;
    localparam logic [2:0] REQ_SPARE_B = 3'd6;
    localparam logic [2:0] REQ_SPARE_C = 3'd7;
    localparam logic [1:0] MS_OTHER    = 2'd2;
    localparam logic [1:0] MS_SPARE    = 2'd3;

    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    fhts_in_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    fhts_out_t   m_data;
    logic        cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    fan_hour_timers_and_sleep i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // timer model: registers and state
    logic [15:0] hour_sec, step_sec, idle_limit;
    logic [7:0]  steps_max;
    logic [3:0]  on_hrs, off_hrs;
    logic [15:0] on_ticks, off_ticks, sleep_ticks, idle_ticks;
    logic [7:0]  sleep_steps_done;
    logic [1:0]  on_code, off_code;
    logic        sleep_on, light_on;

    fhts_in_t  pending_words[$];
    fhts_out_t expected_words[$];

    int words_queued = 0;
    int words_in     = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int settings     = 0;
    int power_on_cnt = 0;
    int stop_cnt     = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    bit idle_on      = 1'b1;

    task automatic reset_model();
        hour_sec         = HOUR_SECONDS_RST;
        step_sec         = SLEEP_STEP_SECONDS_RST;
        steps_max        = SLEEP_STEPS_RST;
        idle_limit       = IDLE_SECONDS_RST;
        on_hrs           = '0;
        off_hrs          = '0;
        on_ticks         = '0;
        off_ticks        = '0;
        sleep_ticks      = '0;
        idle_ticks       = '0;
        sleep_steps_done = '0;
        on_code          = '0;
        off_code         = '0;
        sleep_on         = 1'b0;
        light_on         = 1'b0;
    endtask

    // advance the timer model by one input word and return the result word
    function automatic fhts_out_t predict_word(input fhts_in_t w);
        fhts_out_t r;
        logic      beep_p, on_p, stop_p;
        beep_p = 1'b0;
        on_p   = 1'b0;
        stop_p = 1'b0;
        case (w.req_type)
            REQ_TICK: begin
                if (on_hrs != 0 && w.machine_state == MS_NONE) begin
                    if (int'(on_ticks) + 1 >= int'(hour_sec)) begin
                        on_ticks = '0;
                        on_hrs   = on_hrs - 1'b1;
                        if (on_hrs <= 4'd3) on_code = on_hrs[1:0];
                        if (on_hrs == 0) begin
                            beep_p = 1'b1;
                            on_p   = 1'b1;
                        end
                    end else begin
                        on_ticks = on_ticks + 1'b1;
                    end
                end else begin
                    on_ticks = '0;
                end

                if (off_hrs != 0 && w.machine_state == MS_WORK) begin
                    if (int'(off_ticks) + 1 >= int'(hour_sec)) begin
                        off_ticks = '0;
                        off_hrs   = off_hrs - 1'b1;
                        if (off_hrs <= 4'd3) off_code = off_hrs[1:0];
                        if (off_hrs == 0) begin
                            beep_p = 1'b1;
                            stop_p = 1'b1;
                        end
                    end else begin
                        off_ticks = off_ticks + 1'b1;
                    end
                end else begin
                    off_ticks = '0;
                end

                if (sleep_on && w.machine_state == MS_WORK) begin
                    if (int'(sleep_ticks) + 1 >= int'(step_sec)) begin
                        sleep_ticks = '0;
                        if (int'(sleep_steps_done) + 1 >= int'(steps_max)) begin
                            sleep_steps_done = '0;
                            sleep_on         = 1'b0;
                            beep_p           = 1'b1;
                            stop_p           = 1'b1;
                        end else begin
                            sleep_steps_done = sleep_steps_done + 1'b1;
                        end
                    end else begin
                        sleep_ticks = sleep_ticks + 1'b1;
                    end
                end else begin
                    sleep_ticks      = '0;
                    sleep_steps_done = '0;
                end

                if (w.machine_state == MS_WORK && !light_on) begin
                    if (int'(idle_ticks) + 1 >= int'(idle_limit)) begin
                        idle_ticks = '0;
                        light_on   = 1'b1;
                    end else begin
                        idle_ticks = idle_ticks + 1'b1;
                    end
                end
            end
            REQ_LOAD_ON:   on_hrs   = w.load_value;
            REQ_LOAD_OFF:  off_hrs  = w.load_value;
            REQ_SET_SLEEP: sleep_on = (w.load_value != 0);
            default: ;
        endcase

        // standby clears the light-sleep counter on any word
        if (w.machine_state == MS_NONE) begin
            idle_ticks = '0;
            light_on   = 1'b0;
        end

        r.on_hours_left    = on_hrs;
        r.off_hours_left   = off_hrs;
        r.on_indicator     = on_code;
        r.off_indicator    = off_code;
        r.sleep_active     = sleep_on;
        r.light_sleep      = light_on;
        r.beep             = beep_p;
        r.request_power_on = on_p;
        r.request_stop     = stop_p;
        return r;
    endfunction

    function automatic string word_text(input fhts_out_t w);
        return {$sformatf("on=%0d off=%0d on_ind=%0d off_ind=%0d ",
                          w.on_hours_left, w.off_hours_left, w.on_indicator,
                          w.off_indicator),
                $sformatf("sleep=%0b light=%0b beep=%0b pwr=%0b stop=%0b",
                          w.sleep_active, w.light_sleep, w.beep, w.request_power_on,
                          w.request_stop)};
    endfunction

    // driver: take words from the pending queue, predict on acceptance
    always @(posedge aclk) begin : word_driver
        logic v_next;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            v_next = s_valid;
            if (s_valid && s_ready) begin
                expected_words.push_back(predict_word(s_data));
                words_in = words_in + 1;
                v_next   = 1'b0;
            end
            if (!v_next) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_words.size() != 0) begin
                    s_data   <= pending_words.pop_front();
                    v_next   = 1'b1;
                    gap_left <= idle_on ? $urandom_range(0, 4) : 0;
                end
            end
            s_valid <= v_next;
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge aclk) begin : result_check
        fhts_out_t want;
        int        hold;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            hold = (stall_left > 0) ? stall_left - 1 : 0;
            if (m_valid && m_ready) begin
                results_seen = results_seen + 1;
                if (m_data.request_power_on) power_on_cnt = power_on_cnt + 1;
                if (m_data.request_stop) stop_cnt = stop_cnt + 1;
                if (expected_words.size() == 0) begin
                    if (mismatches < REPORT_MAX)
                        $display("unexpected result word: %s", word_text(m_data));
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.on_hours_left    !== want.on_hours_left    ||
                        m_data.off_hours_left   !== want.off_hours_left   ||
                        m_data.on_indicator     !== want.on_indicator     ||
                        m_data.off_indicator    !== want.off_indicator    ||
                        m_data.sleep_active     !== want.sleep_active     ||
                        m_data.light_sleep      !== want.light_sleep      ||
                        m_data.beep             !== want.beep             ||
                        m_data.request_power_on !== want.request_power_on ||
                        m_data.request_stop     !== want.request_stop) begin
                        if (mismatches < REPORT_MAX) begin
                            $display("result %0d differs", results_seen);
                            $display("  expected %s", word_text(want));
                            $display("  actual   %s", word_text(m_data));
                        end
                        mismatches = mismatches + 1;
                    end
                end
                hold = idle_on ? $urandom_range(0, 4) : 0;
            end
            stall_left <= hold;
            m_ready    <= (hold == 0);
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("fan_hour_timers_and_sleep: mismatch");
            $finish;
        end
    end

    task automatic add_word(input logic [2:0] req, input logic [1:0] ms,
                            input logic [3:0] load);
        fhts_in_t w;
        w.req_type      = req;
        w.machine_state = ms;
        w.load_value    = load;
        pending_words.push_back(w);
        words_queued = words_queued + 1;
    endtask

    function automatic logic [1:0] pick_state();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return MS_NONE;
        if (r < 8) return MS_WORK;
        if (r == 8) return MS_OTHER;
        return MS_SPARE;
    endfunction

    // bursts mostly in one state; mostly ticks, loads and others mixed in
    task automatic add_random(input int count);
        int         left, burst, pick;
        logic [1:0] burst_ms, ms;
        logic [2:0] req;
        logic [3:0] load;
        left = count;
        while (left > 0) begin
            burst_ms = pick_state();
            burst    = $urandom_range(4, 24);
            while (burst > 0 && left > 0) begin
                ms   = ($urandom_range(0, 99) < 85) ? burst_ms : pick_state();
                pick = $urandom_range(0, 99);
                load = 4'($urandom_range(0, 15));
                if (pick < 62) begin
                    req = REQ_TICK;
                end else if (pick < 70) begin
                    req = REQ_STATE;
                end else if (pick < 86) begin
                    req = (pick < 78) ? REQ_LOAD_ON : REQ_LOAD_OFF;
                    if ($urandom_range(0, 9) < 7) load = 4'($urandom_range(1, 4));
                end else if (pick < 94) begin
                    req = REQ_SET_SLEEP;
                    if ($urandom_range(0, 3) == 0) load = '0;
                end else begin
                    req = 3'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
                end
                add_word(req, ms, load);
                burst = burst - 1;
                left  = left - 1;
            end
        end
    endtask

    // hold the sender until every word is through and the pipe is empty
    task automatic drain();
        while (words_in != words_queued || expected_words.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[15:0];
        case (idx)
            CFG_HOUR_SECONDS:       hour_sec   = value[15:0];
            CFG_SLEEP_STEP_SECONDS: step_sec   = value[15:0];
            CFG_SLEEP_STEPS:        steps_max  = value[7:0];
            CFG_IDLE_SECONDS:       idle_limit = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input int hour_v, input int step_v, input int steps_v,
                            input int idle_v);
        drain();
        write_reg(CFG_HOUR_SECONDS, hour_v);
        write_reg(CFG_SLEEP_STEP_SECONDS, step_v);
        write_reg(CFG_SLEEP_STEPS, steps_v);
        write_reg(CFG_IDLE_SECONDS, idle_v);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        settings = settings + 1;
    endtask

    initial begin
        reset_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values of the registers
        idle_on = 1'b1;
        add_random(60);

        // directed: expiries, pulses, unused codes, standby clear
        set_regs(1, 1, 1, 2);
        idle_on = 1'b0;
        add_word(REQ_LOAD_ON,   MS_NONE,  4'd2);
        add_word(REQ_TICK,      MS_NONE,  4'd0);
        add_word(REQ_TICK,      MS_NONE,  4'd0);
        add_word(REQ_LOAD_OFF,  MS_WORK,  4'd15);
        add_word(REQ_TICK,      MS_WORK,  4'd0);
        add_word(REQ_TICK,      MS_WORK,  4'd0);
        add_word(REQ_STATE,     MS_NONE,  4'd15);
        add_word(REQ_LOAD_OFF,  MS_WORK,  4'd1);
        add_word(REQ_SET_SLEEP, MS_WORK,  4'd15);
        add_word(REQ_TICK,      MS_WORK,  4'd0);
        add_word(REQ_SPARE_A,   MS_OTHER, 4'd9);
        add_word(REQ_SPARE_B,   MS_SPARE, 4'd6);
        add_word(REQ_SPARE_C,   MS_SPARE, 4'd15);
        add_word(REQ_TICK,      MS_SPARE, 4'd0);
        add_word(REQ_TICK,      MS_OTHER, 4'd0);
        add_word(REQ_LOAD_ON,   MS_SPARE, 4'd15);
        add_word(REQ_TICK,      MS_NONE,  4'd0);
        add_word(REQ_LOAD_ON,   MS_NONE,  4'd0);
        add_word(REQ_SET_SLEEP, MS_OTHER, 4'd0);
        add_word(REQ_SET_SLEEP, MS_WORK,  4'd1);
        add_word(REQ_TICK,      MS_OTHER, 4'd0);
        add_word(REQ_LOAD_OFF,  MS_WORK,  4'd3);
        add_word(REQ_TICK,      MS_WORK,  4'd0);
        add_word(REQ_TICK,      MS_WORK,  4'd0);
        add_word(REQ_TICK,      MS_NONE,  4'd15);

        set_regs(2, 1, 2, 3);
        idle_on = 1'b1;
        add_random(150);

        set_regs(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        add_random(60);

        set_regs(1, 1, 1, 1);
        idle_on = 1'b0;
        add_random(150);

        // zero registers expire on every running tick
        set_regs(0, 0, 0, 0);
        idle_on = 1'b1;
        add_random(60);

        set_regs(6, 4, 3, 10);
        add_random(150);

        // lower the registers under counts already in flight
        set_regs(1, 1, 1, 2);
        add_random(100);

        repeat (2) begin
            set_regs($urandom_range(1, 5), $urandom_range(1, 4), $urandom_range(1, 4),
                     $urandom_range(1, 8));
            add_random(150);
        end

        drain();
        repeat (8) @(posedge aclk);

        if (expected_words.size() != 0) begin
            $display("%0d result words never arrived", expected_words.size());
            mismatches = mismatches + expected_words.size();
        end
        $display("Covered %0d input words and %0d result words over %0d register settings.",
                 words_in, results_seen, settings);
        $display("Saw %0d power-on and %0d stop requests; %0d words differed.",
                 power_on_cnt, stop_cnt, mismatches);
        if (mismatches == 0)
            $display("fan_hour_timers_and_sleep: match");
        else
            $display("fan_hour_timers_and_sleep: mismatch");
        $finish;
    end

endmodule
